@@ src/general_matrix_multiply_assert.svh @@
// Assertion macros for the general matrix multiply block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GENERAL_MATRIX_MULTIPLY_ASSERT_SVH
`define GENERAL_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication; the consequent may start with a ## delay.
`define GMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication.
`define GMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/gmm_pkg.sv @@
// Shared types, constants and helpers for the general matrix multiply block.
// Depends on nothing; the sequencer, MAC unit, top and checker import it.
package gmm_pkg;

    localparam int MAX_DIM    = 16;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int CELLS       = MAX_DIM * MAX_DIM;
    localparam int DIM_W       = 5;
    localparam int ACTION_W    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SCALE_W     = 16;

    // Accumulator holds a sum of up to MAX_DIM full products.
    localparam int ACC_W       = 2 * DATA_WIDTH + $clog2(MAX_DIM);
    localparam int PROD_W      = SCALE_W + ACC_W;
    localparam int TOT_W       = PROD_W + 1;
    localparam int ROUND_SHIFT = 2 * FRAC_BITS;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_A  = 3'd0,
        ACT_LOAD_B  = 3'd1,
        ACT_LOAD_C  = 3'd2,
        ACT_COMPUTE = 3'd3,
        ACT_READ_C  = 3'd4
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TRANSPOSE_A = 3'd0,
        REG_TRANSPOSE_B = 3'd1,
        REG_ROWS_M      = 3'd2,
        REG_COLS_N      = 3'd3,
        REG_INNER_K     = 3'd4,
        REG_ALPHA       = 3'd5,
        REG_BETA        = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        MUL_AB    = 2'd0,
        MUL_BETA  = 2'd1,
        MUL_ALPHA = 2'd2
    } mul_sel_t;

    // Control word from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic     prod_load;
        mul_sel_t mul_sel;
        logic     acc_clear;
        logic     acc_add;
        logic     tot_load;
        logic     tot_add;
        logic     c_write;
    } gmm_ctrl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (d > lim) ? lim : d;
    endfunction

endpackage

@@ src/gmm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/gmm_seq.sv @@
// Compute sequencer: walks i, j and k over the result region and drives the
// arithmetic unit one step at a time. Depends on gmm_pkg.
module gmm_seq
    import gmm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIM_W-1:0] m_dim,
    input  logic [DIM_W-1:0] n_dim,
    input  logic [DIM_W-1:0] k_dim,
    output gmm_ctrl_t        ctrl,
    output logic [IDX_W-1:0] row_i,
    output logic [IDX_W-1:0] col_j,
    output logic [IDX_W-1:0] step_k,
    output logic             busy
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FETCH = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_ACC   = 8'b0000_1000,
        ST_BETA  = 8'b0001_0000,
        ST_ALPHA = 8'b0010_0000,
        ST_SUM   = 8'b0100_0000,
        ST_WRITE = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             last_i, last_j, last_k;

    assign last_i = (DIM_W'(i_reg) + DIM_W'(1)) == m_dim;
    assign last_j = (DIM_W'(j_reg) + DIM_W'(1)) == n_dim;
    assign last_k = (DIM_W'(k_reg) + DIM_W'(1)) == k_dim;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        ctrl       = '0;
        ctrl.mul_sel = MUL_AB;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    i_next = '0;
                    j_next = '0;
                    k_next = '0;
                    ctrl.acc_clear = 1'b1;
                    if (m_dim != '0 && n_dim != '0)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = (k_dim == '0) ? ST_BETA : ST_MUL;
            end
            ST_MUL:
            begin
                ctrl.prod_load = 1'b1;
                ctrl.mul_sel   = MUL_AB;
                state_next     = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.acc_add = 1'b1;
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = ST_BETA;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_BETA:
            begin
                ctrl.prod_load = 1'b1;
                ctrl.mul_sel   = MUL_BETA;
                state_next     = ST_ALPHA;
            end
            ST_ALPHA:
            begin
                ctrl.tot_load  = 1'b1;
                ctrl.prod_load = 1'b1;
                ctrl.mul_sel   = MUL_ALPHA;
                state_next     = ST_SUM;
            end
            ST_SUM:
            begin
                ctrl.tot_add = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                ctrl.c_write   = 1'b1;
                ctrl.acc_clear = 1'b1;
                state_next     = ST_FETCH;
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    assign row_i  = i_reg;
    assign col_j  = j_reg;
    assign step_k = k_reg;
    assign busy   = (state_reg != ST_IDLE);

endmodule

@@ src/gmm_mac_unit.sv @@
// Shared multiplier with accumulator, scaling sum and Q8.8 round/saturate.
// Depends on gmm_pkg; steered by the control word from gmm_seq.
module gmm_mac_unit
    import gmm_pkg::*;
(
    input  logic                         clk,
    input  gmm_ctrl_t                    ctrl,
    input  logic signed [DATA_WIDTH-1:0] a_data,
    input  logic signed [DATA_WIDTH-1:0] b_data,
    input  logic signed [DATA_WIDTH-1:0] c_data,
    input  logic signed [SCALE_W-1:0]    alpha,
    input  logic signed [SCALE_W-1:0]    beta,
    output logic        [DATA_WIDTH-1:0] value,
    output logic                         clip
);

    localparam int SCALED_W = TOT_W - ROUND_SHIFT;
    localparam logic signed [TOT_W-1:0] ROUND_BIAS = TOT_W'(1) << (ROUND_SHIFT - 1);
    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [SCALE_W-1:0]  mul_a;
    logic signed [ACC_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod_w;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [TOT_W-1:0]    tot_reg, tot_next;
    logic signed [SCALED_W-1:0] scaled;
    logic [SCALED_W-DATA_WIDTH:0] upper;

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_AB:
            begin
                mul_a = SCALE_W'(a_data);
                mul_b = ACC_W'(b_data);
            end
            MUL_BETA:
            begin
                mul_a = beta;
                mul_b = ACC_W'(c_data);
            end
            MUL_ALPHA:
            begin
                mul_a = alpha;
                mul_b = acc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_w = mul_a * mul_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // The beta term is placed at the alpha term's binary point before the sum.
    always_comb
    begin
        tot_next = tot_reg;
        if (ctrl.tot_load)
        begin
            tot_next = TOT_W'(prod_reg) <<< FRAC_BITS;
        end
        else if (ctrl.tot_add)
        begin
            tot_next = tot_reg + TOT_W'(prod_reg) + ROUND_BIAS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_load)
        begin
            prod_reg <= prod_w;
        end
        acc_reg <= acc_next;
        tot_reg <= tot_next;
    end

    // Arithmetic shift is the floor; out of range when the top bits disagree.
    assign scaled = tot_reg[TOT_W-1:ROUND_SHIFT];
    assign upper  = scaled[SCALED_W-1:DATA_WIDTH-1];
    assign clip   = !((&upper) || (~|upper));
    assign value  = clip ? (scaled[SCALED_W-1] ? SAT_MIN : SAT_MAX)
                         : scaled[DATA_WIDTH-1:0];

endmodule

@@ src/general_matrix_multiply.sv @@
// Top level of the general matrix multiply block: stores, configuration,
// word channels. Depends on gmm_pkg, gmm_ram, gmm_seq and gmm_mac_unit.
//
// This block computes C = beta*C + alpha*op(A)*op(B) in signed Q8.8, where
// op() optionally transposes the stored A or B. A, B and C live in three
// 16x16 RAMs addressed by stored row and column; their contents are
// undefined until loaded, and no element may be used before it is written.
// Load and read words are taken one per cycle while in_stall is low. A
// read returns its C element and clip flag through the registered RAM
// read and the output register, and the output register lets the next
// word in while a result waits to be taken. A compute word clears all clip
// flags; in_stall is high while the block computes (not if M or N is 0):
// every multiply, the beta and alpha scaling included, runs through one
// shared multiplier, and each inner step costs a registered RAM read, a
// multiply and an accumulate. Every element is rounded half up back to Q8.8
// and saturated, and a clipped element gets its clip flag set. Dimensions
// above 16 act as 16. The user must write configuration through the plain
// write port only while the block is idle; the block does not enforce it.
// Unknown register indexes and unknown actions are ignored.
module general_matrix_multiply
    import gmm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ACTION_W-1:0]    action,
    input  logic [IDX_W-1:0]       row_index,
    input  logic [IDX_W-1:0]       col_index,
    input  logic [DATA_WIDTH-1:0]  data_value,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [IDX_W-1:0]       result_row,
    output logic [IDX_W-1:0]       result_col,
    output logic [DATA_WIDTH-1:0]  result_value,
    output logic                   saturated
);

    // Configuration registers.
    logic               transpose_a_reg;
    logic               transpose_b_reg;
    logic [DIM_W-1:0]   rows_m_reg;
    logic [DIM_W-1:0]   cols_n_reg;
    logic [DIM_W-1:0]   inner_k_reg;
    logic [SCALE_W-1:0] alpha_reg;
    logic [SCALE_W-1:0] beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transpose_a_reg <= 1'b0;
            transpose_b_reg <= 1'b0;
            rows_m_reg      <= DIM_W'(1);
            cols_n_reg      <= DIM_W'(1);
            inner_k_reg     <= DIM_W'(1);
            alpha_reg       <= SCALE_W'(256);
            beta_reg        <= SCALE_W'(256);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TRANSPOSE_A: transpose_a_reg <= cfg_wdata[0];
                REG_TRANSPOSE_B: transpose_b_reg <= cfg_wdata[0];
                REG_ROWS_M:      rows_m_reg      <= cfg_wdata[DIM_W-1:0];
                REG_COLS_N:      cols_n_reg      <= cfg_wdata[DIM_W-1:0];
                REG_INNER_K:     inner_k_reg     <= cfg_wdata[DIM_W-1:0];
                REG_ALPHA:       alpha_reg       <= cfg_wdata[SCALE_W-1:0];
                REG_BETA:        beta_reg        <= cfg_wdata[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input word decode.
    logic       in_accept;
    logic       busy;
    logic       is_load_a, is_load_b, is_load_c, is_compute, is_read;
    logic [ADDR_W-1:0] in_addr;

    assign in_accept  = in_valid && !in_stall;
    assign in_addr    = {row_index, col_index};

    always_comb
    begin
        is_load_a  = 1'b0;
        is_load_b  = 1'b0;
        is_load_c  = 1'b0;
        is_compute = 1'b0;
        is_read    = 1'b0;
        case (action)
            ACT_LOAD_A:  is_load_a  = in_accept;
            ACT_LOAD_B:  is_load_b  = in_accept;
            ACT_LOAD_C:  is_load_c  = in_accept;
            ACT_COMPUTE: is_compute = in_accept;
            ACT_READ_C:  is_read    = in_accept;
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    gmm_ctrl_t        ctrl;
    logic [IDX_W-1:0] seq_i, seq_j, seq_k;

    gmm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (is_compute),
        .m_dim  (clamp_dim(rows_m_reg)),
        .n_dim  (clamp_dim(cols_n_reg)),
        .k_dim  (clamp_dim(inner_k_reg)),
        .ctrl   (ctrl),
        .row_i  (seq_i),
        .col_j  (seq_j),
        .step_k (seq_k),
        .busy   (busy)
    );

    // Operand addressing: op(A)[i][k] and op(B)[k][j] by the transpose bits.
    logic [ADDR_W-1:0] a_raddr, b_raddr, c_cur_addr;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0] c_raddr, c_waddr;

    assign a_raddr    = transpose_a_reg ? {seq_k, seq_i} : {seq_i, seq_k};
    assign b_raddr    = transpose_b_reg ? {seq_j, seq_k} : {seq_k, seq_j};
    assign c_cur_addr = {seq_i, seq_j};

    // The read address holds while a read waits, so the RAM output holds too.
    assign rd_addr_next = is_read ? in_addr : rd_addr_reg;
    assign c_raddr      = busy ? c_cur_addr : rd_addr_next;
    assign c_waddr      = ctrl.c_write ? c_cur_addr : in_addr;

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
    end

    logic [DATA_WIDTH-1:0] a_rdata, b_rdata, c_rdata, c_wdata;
    logic [DATA_WIDTH-1:0] mac_value;
    logic                  mac_clip;
    logic                  clip_rdata;

    assign c_wdata = ctrl.c_write ? mac_value : data_value;

    gmm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_a_ram (
        .clk   (clk),
        .we    (is_load_a),
        .waddr (in_addr),
        .wdata (data_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    gmm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_b_ram (
        .clk   (clk),
        .we    (is_load_b),
        .waddr (in_addr),
        .wdata (data_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    gmm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_c_ram (
        .clk   (clk),
        .we    (is_load_c || ctrl.c_write),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // Clip flags: RAM plus one valid bit per element; compute clears them all.
    gmm_ram #(.WIDTH(1), .DEPTH(CELLS)) u_clip_ram (
        .clk   (clk),
        .we    (ctrl.c_write),
        .waddr (c_cur_addr),
        .wdata (mac_clip),
        .raddr (c_raddr),
        .rdata (clip_rdata)
    );

    logic [CELLS-1:0] clip_vld_reg;
    logic             clip_vld_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_vld_reg <= '0;
        end
        else if (is_compute)
        begin
            clip_vld_reg <= '0;
        end
        else if (ctrl.c_write)
        begin
            clip_vld_reg[c_cur_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        clip_vld_q_reg <= clip_vld_reg[c_raddr];
    end

    gmm_mac_unit u_mac (
        .clk    (clk),
        .ctrl   (ctrl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .c_data (c_rdata),
        .alpha  (alpha_reg),
        .beta   (beta_reg),
        .value  (mac_value),
        .clip   (mac_clip)
    );

    // Read path: one pending stage over the RAM latency, then the output word.
    logic                  rd_pend_reg, rd_pend_next;
    logic                  out_load;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]      out_row_reg, out_col_reg;
    logic [DATA_WIDTH-1:0] out_value_reg;
    logic                  out_sat_reg;

    assign out_load       = rd_pend_reg && (!out_valid_reg || !result_stall);
    assign rd_pend_next   = is_read || (rd_pend_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && result_stall);
    assign in_stall       = busy || (rd_pend_reg && !out_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg   <= rd_addr_reg[ADDR_W-1:IDX_W];
            out_col_reg   <= rd_addr_reg[IDX_W-1:0];
            out_value_reg <= c_rdata;
            out_sat_reg   <= clip_rdata && clip_vld_q_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_row   = out_row_reg;
    assign result_col   = out_col_reg;
    assign result_value = out_value_reg;
    assign saturated    = out_sat_reg;

endmodule

@@ src/gmm_checker.sv @@
// Port-level checker for the general matrix multiply block and its bind.
// Depends on gmm_pkg and general_matrix_multiply_assert.svh.
`include "general_matrix_multiply_assert.svh"

module gmm_checker
    import gmm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic [ACTION_W-1:0]    action,
    input logic [IDX_W-1:0]       row_index,
    input logic [IDX_W-1:0]       col_index,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [IDX_W-1:0]       result_row,
    input logic [IDX_W-1:0]       result_col,
    input logic [DATA_WIDTH-1:0]  result_value,
    input logic                   saturated
);

    logic                        read_taken;
    logic                        result_waits;
    logic                        result_fresh;
    logic                        valid_q_reg;
    logic [2*IDX_W-1:0]          read_pos;
    logic [2*IDX_W-1:0]          result_pos;
    logic [2*IDX_W+DATA_WIDTH:0] result_word;

    assign read_taken   = in_valid && !in_stall && (action == ACT_READ_C);
    assign result_waits = result_valid && result_stall;
    assign read_pos     = {row_index, col_index};
    assign result_pos   = {result_row, result_col};
    assign result_word  = {result_row, result_col, result_value, saturated};

    // A result word is fresh in the first cycle it shows valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_q_reg <= 1'b0;
        end
        else
        begin
            valid_q_reg <= result_valid;
        end
    end

    assign result_fresh = result_valid && !valid_q_reg;

    // A stalled result word keeps its contents.
    `GMM_ASSERT_NEXT(a_result_hold, result_waits, result_valid && $stable(result_word), "word moved")

    // Every read shows a word on the output after the RAM read and output registers.
    `GMM_ASSERT_NOW(a_read_reaches_output, read_taken, ##2 result_valid, "read never came out")

    // A fresh result word comes from an earlier read, through the RAM read and output registers.
    `GMM_ASSERT_NOW(a_result_has_read, result_fresh, $past(read_taken, 2), "result without a read")

    // It carries the position of that read.
    `GMM_ASSERT_NOW(a_result_position, result_fresh, result_pos == $past(read_pos, 2), "misplaced")

endmodule

bind general_matrix_multiply gmm_checker u_gmm_checker (.*);
